@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the LRU victim selector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LVS_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define LVS_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LVS_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/lvs_pkg.sv @@
// Shared constants and codes of the LRU victim selector.
package lvs_pkg;

    localparam int MAX_ENTRIES_DEF = 64;

    localparam int ID_W    = 16;
    localparam int STAMP_W = 64;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 3;

    localparam logic [COUNT_W-1:0] CAP_RESET   = 7'd64;
    localparam logic [STAMP_W-1:0] CLOCK_RESET = 64'd1;

    // request kinds
    localparam logic KIND_TOUCH  = 1'b0;
    localparam logic KIND_SELECT = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_RESTAMP = 3'd0;
    localparam logic [STAT_W-1:0] ST_INSERT  = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STAT_W-1:0] ST_VICTIM  = 3'd3;
    localparam logic [STAT_W-1:0] ST_NONE    = 3'd4;

endpackage

@@ rtl/core/lvs_if.sv @@
// Request and result channel interfaces of the LRU victim selector.
interface lvs_req_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [lvs_pkg::ID_W-1:0]    line_id;
    logic [lvs_pkg::COUNT_W-1:0] victim_count;

    modport source (output valid, kind, line_id, victim_count, input ready);
    modport sink   (input valid, kind, line_id, victim_count, output ready);
endinterface

interface lvs_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [lvs_pkg::STAT_W-1:0]  status;
    logic [lvs_pkg::ID_W-1:0]    victim_id;
    logic [lvs_pkg::COUNT_W-1:0] tracked_count;
    logic                        last;

    modport source (output valid, status, victim_id, tracked_count, last, input ready);
    modport sink   (input valid, status, victim_id, tracked_count, last, output ready);
endinterface

@@ rtl/core/lvs_entry_ram.sv @@
// Entry table memory: block ids and last-use stamps, one read and one write port.
module lvs_entry_ram #(
    parameter int DEPTH = lvs_pkg::MAX_ENTRIES_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        wr_id_en,
    input  logic                        wr_stamp_en,
    input  logic [IDX_W-1:0]            wr_addr,
    input  logic [lvs_pkg::ID_W-1:0]    wr_id,
    input  logic [lvs_pkg::STAMP_W-1:0] wr_stamp,
    input  logic                        rd_en,
    input  logic [IDX_W-1:0]            rd_addr,
    output logic [lvs_pkg::ID_W-1:0]    rd_id,
    output logic [lvs_pkg::STAMP_W-1:0] rd_stamp
);

    logic [lvs_pkg::ID_W-1:0]    id_mem    [DEPTH];
    logic [lvs_pkg::STAMP_W-1:0] stamp_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_id_en)
        begin
            id_mem[wr_addr] <= wr_id;
        end
        if (wr_stamp_en)
        begin
            stamp_mem[wr_addr] <= wr_stamp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_id    <= id_mem[rd_addr];
            rd_stamp <= stamp_mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/lru_victim_selector_core.sv @@
// Top level of the LRU victim selector: table scan sequencer and result register.
//
// LRU victim selector. Keeps up to MAX_ENTRIES block ids, each stamped with a
// 64-bit use clock that starts at 1. A touch request (kind 0) restamps an id
// already held, appends it while occupancy is below capacity_limit (clamped to
// MAX_ENTRIES), or is ignored when the table is full; it gives one result. A
// select request (kind 1) returns min(victim_count, occupancy) victims, oldest
// stamp first, ties to the lower table slot, table unchanged; last marks the
// final one. victim_count 0 or an empty table gives one nothing-to-evict result.
// Every result carries the occupancy after the request. The table sits in
// a memory with one read and one write port and registered read, walked one
// slot a cycle through one shared id/stamp compare unit. A touch scans every
// held entry once; a select scans every held entry once per victim. A select
// with nothing to evict, or a touch on an empty table, skips the scan. The
// block waits while the result register stays full and a result is ready
// to load. Results sit in an output register, so a new request is accepted
// while the previous result waits, but a select stalls between victims while
// its result register is not drained. capacity_limit is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle, as
// the block itself does not enforce this.
`include "assert_macros.svh"

module lru_victim_selector_core #(
    parameter int MAX_ENTRIES = lvs_pkg::MAX_ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lvs_pkg::COUNT_W-1:0] cfg_wdata,
    lvs_req_if.sink                     req,
    lvs_rsp_if.source                   rsp
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (OCC_W > lvs_pkg::COUNT_W) ? OCC_W : lvs_pkg::COUNT_W;
    localparam logic [OCC_W-1:0] MAX_OCC = OCC_W'(MAX_ENTRIES);

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0] state_reg, state_next;

    // architectural state
    logic [lvs_pkg::COUNT_W-1:0] cap_reg;
    logic [OCC_W-1:0]            occ_reg, occ_next;
    logic [lvs_pkg::STAMP_W-1:0] clock_reg, clock_next;

    // request context
    logic                     kind_reg, kind_next;
    logic [lvs_pkg::ID_W-1:0] bid_reg, bid_next;
    logic [OCC_W-1:0]         want_reg, want_next;
    logic                     none_reg, none_next;
    logic [OCC_W-1:0]         vcnt_reg, vcnt_next;

    // scan pipeline
    logic [OCC_W-1:0] iss_reg, iss_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;

    // touch search result
    logic             found_reg, found_next;
    logic [IDX_W-1:0] fidx_reg, fidx_next;

    // select: current best and previous victim
    logic                        best_vld_reg, best_vld_next;
    logic [lvs_pkg::STAMP_W-1:0] best_stamp_reg, best_stamp_next;
    logic [IDX_W-1:0]            best_idx_reg, best_idx_next;
    logic [lvs_pkg::ID_W-1:0]    best_id_reg, best_id_next;
    logic                        prev_vld_reg, prev_vld_next;
    logic [lvs_pkg::STAMP_W-1:0] prev_stamp_reg, prev_stamp_next;
    logic [IDX_W-1:0]            prev_idx_reg, prev_idx_next;

    // result register
    logic                        out_vld_reg, out_vld_next;
    logic [lvs_pkg::STAT_W-1:0]  out_stat_reg, out_stat_next;
    logic [lvs_pkg::ID_W-1:0]    out_id_reg, out_id_next;
    logic [lvs_pkg::COUNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic                        out_last_reg, out_last_next;

    // memory ports
    logic                        wr_id_en, wr_stamp_en;
    logic [IDX_W-1:0]            wr_addr;
    logic                        rd_en;
    logic [IDX_W-1:0]            rd_addr;
    logic [lvs_pkg::ID_W-1:0]    rd_id;
    logic [lvs_pkg::STAMP_W-1:0] rd_stamp;

    // combinational helpers
    logic             out_free;
    logic             out_load;
    logic             accept;
    logic             full;
    logic             cand;
    logic             better;
    logic             id_hit;
    logic             is_last;
    logic [CMP_W-1:0] vc_ext;
    logic [CMP_W-1:0] occ_ext;
    logic [CMP_W-1:0] occn_ext;
    logic [CMP_W-1:0] cap_ext;

    lvs_entry_ram #(
        .DEPTH (MAX_ENTRIES),
        .IDX_W (IDX_W)
    ) u_ram (
        .clk         (clk),
        .wr_id_en    (wr_id_en),
        .wr_stamp_en (wr_stamp_en),
        .wr_addr     (wr_addr),
        .wr_id       (bid_reg),
        .wr_stamp    (clock_reg),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_id       (rd_id),
        .rd_stamp    (rd_stamp)
    );

    assign req.ready         = (state_reg == S_IDLE);
    assign accept            = req.valid && req.ready;
    assign rsp.valid         = out_vld_reg;
    assign rsp.status        = out_stat_reg;
    assign rsp.victim_id     = out_id_reg;
    assign rsp.tracked_count = out_cnt_reg;
    assign rsp.last          = out_last_reg;

    assign out_free = !out_vld_reg || rsp.ready;

    assign vc_ext   = CMP_W'(req.victim_count);
    assign occ_ext  = CMP_W'(occ_reg);
    assign occn_ext = CMP_W'(occ_next);
    assign cap_ext  = CMP_W'(cap_reg);
    assign full     = (occ_ext >= cap_ext) || (occ_reg == MAX_OCC);

    // shared compare unit, fed by the memory read data
    assign id_hit = (rd_id == bid_reg);
    assign cand   = !prev_vld_reg || (rd_stamp > prev_stamp_reg) ||
                    ((rd_stamp == prev_stamp_reg) && (pidx_reg > prev_idx_reg));
    assign better = !best_vld_reg || (rd_stamp < best_stamp_reg);

    assign is_last = ((vcnt_reg + OCC_W'(1)) == want_reg);

    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        clock_next      = clock_reg;
        kind_next       = kind_reg;
        bid_next        = bid_reg;
        want_next       = want_reg;
        none_next       = none_reg;
        vcnt_next       = vcnt_reg;
        iss_next        = iss_reg;
        pend_next       = 1'b0;
        pidx_next       = pidx_reg;
        found_next      = found_reg;
        fidx_next       = fidx_reg;
        best_vld_next   = best_vld_reg;
        best_stamp_next = best_stamp_reg;
        best_idx_next   = best_idx_reg;
        best_id_next    = best_id_reg;
        prev_vld_next   = prev_vld_reg;
        prev_stamp_next = prev_stamp_reg;
        prev_idx_next   = prev_idx_reg;
        out_vld_next    = out_vld_reg && !rsp.ready;
        out_stat_next   = out_stat_reg;
        out_id_next     = out_id_reg;
        out_cnt_next    = out_cnt_reg;
        out_last_next   = out_last_reg;
        out_load        = 1'b0;
        wr_id_en        = 1'b0;
        wr_stamp_en     = 1'b0;
        wr_addr         = occ_reg[IDX_W-1:0];
        rd_en           = 1'b0;
        rd_addr         = iss_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next     = req.kind;
                    bid_next      = req.line_id;
                    want_next     = (vc_ext > occ_ext) ? occ_reg : vc_ext[OCC_W-1:0];
                    none_next     = (req.victim_count == '0) || (occ_reg == '0);
                    vcnt_next     = '0;
                    iss_next      = '0;
                    found_next    = 1'b0;
                    best_vld_next = 1'b0;
                    prev_vld_next = 1'b0;
                    if (req.kind == lvs_pkg::KIND_TOUCH)
                    begin
                        state_next = (occ_reg == '0) ? S_DECIDE : S_SCAN;
                    end
                    else
                    begin
                        state_next = ((req.victim_count == '0) || (occ_reg == '0)) ?
                                     S_EMIT : S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one read a cycle
                if (iss_reg != occ_reg)
                begin
                    rd_en     = 1'b1;
                    iss_next  = iss_reg + OCC_W'(1);
                    pend_next = 1'b1;
                    pidx_next = iss_reg[IDX_W-1:0];
                end
                // evaluate the slot read last cycle
                if (pend_reg)
                begin
                    if (kind_reg == lvs_pkg::KIND_TOUCH)
                    begin
                        if (id_hit && !found_reg)
                        begin
                            found_next = 1'b1;
                            fidx_next  = pidx_reg;
                        end
                    end
                    else if (cand && better)
                    begin
                        best_vld_next   = 1'b1;
                        best_stamp_next = rd_stamp;
                        best_idx_next   = pidx_reg;
                        best_id_next    = rd_id;
                    end
                end
                if ((iss_reg == occ_reg) && !pend_reg)
                begin
                    state_next = (kind_reg == lvs_pkg::KIND_TOUCH) ? S_DECIDE : S_EMIT;
                end
            end

            S_DECIDE:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_vld_next  = 1'b1;
                    out_id_next   = '0;
                    out_last_next = 1'b1;
                    if (found_reg)
                    begin
                        wr_stamp_en   = 1'b1;
                        wr_addr       = fidx_reg;
                        clock_next    = clock_reg + lvs_pkg::STAMP_W'(1);
                        out_stat_next = lvs_pkg::ST_RESTAMP;
                    end
                    else if (full)
                    begin
                        out_stat_next = lvs_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_id_en      = 1'b1;
                        wr_stamp_en   = 1'b1;
                        clock_next    = clock_reg + lvs_pkg::STAMP_W'(1);
                        occ_next      = occ_reg + OCC_W'(1);
                        out_stat_next = lvs_pkg::ST_INSERT;
                    end
                    out_cnt_next = occn_ext[lvs_pkg::COUNT_W-1:0];
                    state_next   = S_IDLE;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    out_vld_next = 1'b1;
                    out_cnt_next = occ_ext[lvs_pkg::COUNT_W-1:0];
                    if (none_reg)
                    begin
                        out_stat_next = lvs_pkg::ST_NONE;
                        out_id_next   = '0;
                        out_last_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        out_stat_next = lvs_pkg::ST_VICTIM;
                        out_id_next   = best_id_reg;
                        out_last_next = is_last;
                        if (is_last)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            // next victim: strictly after this one in (stamp, slot) order
                            prev_vld_next   = 1'b1;
                            prev_stamp_next = best_stamp_reg;
                            prev_idx_next   = best_idx_reg;
                            best_vld_next   = 1'b0;
                            vcnt_next       = vcnt_reg + OCC_W'(1);
                            iss_next        = '0;
                            state_next      = S_SCAN;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cap_reg      <= lvs_pkg::CAP_RESET;
            occ_reg      <= '0;
            clock_reg    <= lvs_pkg::CLOCK_RESET;
            pend_reg     <= 1'b0;
            found_reg    <= 1'b0;
            best_vld_reg <= 1'b0;
            prev_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            clock_reg    <= clock_next;
            pend_reg     <= pend_next;
            found_reg    <= found_next;
            best_vld_reg <= best_vld_next;
            prev_vld_reg <= prev_vld_next;
            out_vld_reg  <= out_vld_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // payload and context, no reset needed
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        bid_reg        <= bid_next;
        want_reg       <= want_next;
        none_reg       <= none_next;
        vcnt_reg       <= vcnt_next;
        iss_reg        <= iss_next;
        pidx_reg       <= pidx_next;
        fidx_reg       <= fidx_next;
        best_stamp_reg <= best_stamp_next;
        best_idx_reg   <= best_idx_next;
        best_id_reg    <= best_id_next;
        prev_stamp_reg <= prev_stamp_next;
        prev_idx_reg   <= prev_idx_next;
        out_stat_reg   <= out_stat_next;
        out_id_reg     <= out_id_next;
        out_cnt_reg    <= out_cnt_next;
        out_last_reg   <= out_last_next;
    end

    `LVS_ALWAYS(a_occ_bound, occ_reg <= MAX_OCC, "occupancy above table depth")
    `LVS_IMPLIES(a_load_free, out_load, out_free, "result register overwritten while held")
    `LVS_IMPLIES(a_occ_step, occ_reg != $past(occ_reg),
                 occ_reg == $past(occ_reg) + OCC_W'(1), "occupancy moved by other than one")
    `LVS_IMPLIES(a_none_last, rsp.valid && (rsp.status == lvs_pkg::ST_NONE),
                 rsp.last, "nothing-to-evict result not marked last")

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for lru_victim_selector_core: directed table, random phases.
module testbench;
    import lvs_pkg::*;

    localparam int SLOTS        = MAX_ENTRIES_DEF;
    // Cycles with no request or result moving before the run is declared hung.
    // Worst honest stretch: one victim scan at full table plus a long receiver
    // stall or a config settle pause.
    localparam int STALL_LIMIT  = 2000;
    localparam int CFG_SETTLE   = 8;    // idle cycles before a capacity write
    localparam int DRAIN_CYCLES = 80;   // about one full-table scan

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ID_W-1:0]    victim_id;
        logic [COUNT_W-1:0] tracked_count;
        logic               last;
    } lru_result_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_op_e;

    // One row of the directed table. For ROW_CFG, amount is the capacity value.
    // For ROW_REQ with typed set, status/tracked are the single known result.
    typedef struct packed {
        row_op_e            op;
        logic               kind;
        logic [ID_W-1:0]    line_id;
        logic [COUNT_W-1:0] amount;
        logic               typed;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] tracked;
    } plan_row_t;

    localparam plan_row_t PLAN [21] = '{
        // select on an empty table
        '{ROW_REQ, KIND_SELECT, 16'h0000, 7'd5,   1'b1, ST_NONE,    7'd0},
        // fill with the id extremes and one pattern
        '{ROW_REQ, KIND_TOUCH,  16'h0000, 7'd0,   1'b1, ST_INSERT,  7'd1},
        '{ROW_REQ, KIND_TOUCH,  16'hFFFF, 7'd127, 1'b1, ST_INSERT,  7'd2},
        '{ROW_REQ, KIND_TOUCH,  16'h5A5A, 7'd0,   1'b1, ST_INSERT,  7'd3},
        '{ROW_REQ, KIND_TOUCH,  16'h0000, 7'd0,   1'b1, ST_RESTAMP, 7'd3},
        // zero victims asked
        '{ROW_REQ, KIND_SELECT, 16'hFFFF, 7'd0,   1'b1, ST_NONE,    7'd3},
        // more victims than entries, then a partial select
        '{ROW_REQ, KIND_SELECT, 16'h0000, 7'd64,  1'b0, ST_RESTAMP, 7'd0},
        '{ROW_REQ, KIND_SELECT, 16'h0000, 7'd2,   1'b0, ST_RESTAMP, 7'd0},
        // limit below occupancy: new ids refused, old ones still restamp
        '{ROW_CFG, KIND_TOUCH,  16'h0000, 7'd1,   1'b0, ST_RESTAMP, 7'd0},
        '{ROW_REQ, KIND_TOUCH,  16'h1234, 7'd0,   1'b1, ST_FULL,    7'd3},
        '{ROW_REQ, KIND_TOUCH,  16'hFFFF, 7'd0,   1'b1, ST_RESTAMP, 7'd3},
        // zero limit admits nothing
        '{ROW_CFG, KIND_TOUCH,  16'h0000, 7'd0,   1'b0, ST_RESTAMP, 7'd0},
        '{ROW_REQ, KIND_TOUCH,  16'hA5A5, 7'd0,   1'b1, ST_FULL,    7'd3},
        // limit above the built depth saturates
        '{ROW_CFG, KIND_TOUCH,  16'h0000, 7'd127, 1'b0, ST_RESTAMP, 7'd0},
        '{ROW_REQ, KIND_TOUCH,  16'hA5A5, 7'd0,   1'b1, ST_INSERT,  7'd4},
        '{ROW_REQ, KIND_TOUCH,  16'h8001, 7'd64,  1'b1, ST_INSERT,  7'd5},
        '{ROW_REQ, KIND_SELECT, 16'h0000, 7'd1,   1'b0, ST_RESTAMP, 7'd0},
        '{ROW_REQ, KIND_SELECT, 16'h0000, 7'd5,   1'b0, ST_RESTAMP, 7'd0},
        '{ROW_REQ, KIND_TOUCH,  16'h5A5A, 7'd0,   1'b0, ST_RESTAMP, 7'd0},
        '{ROW_REQ, KIND_SELECT, 16'hFFFF, 7'd64,  1'b0, ST_RESTAMP, 7'd0},
        '{ROW_CFG, KIND_TOUCH,  16'h0000, 7'd64,  1'b0, ST_RESTAMP, 7'd0}
    };

    // Random phases: capacity, request count, share of touches with a fresh id.
    localparam logic [COUNT_W-1:0] PHASE_CAP   [5] = '{7'd8, 7'd12, 7'd64, 7'd1, 7'd100};
    localparam int                 PHASE_ITEMS [5] = '{30, 30, 60, 20, 40};
    localparam int                 PHASE_FRESH [5] = '{40, 40, 80, 40, 80};

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;

    lvs_req_if req_bus ();
    lvs_rsp_if rsp_bus ();

    lru_victim_selector_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_bus),
        .rsp       (rsp_bus)
    );

    // Shadow copy of the table, clock and capacity register.
    logic [ID_W-1:0]    slot_ids    [SLOTS];
    logic [STAMP_W-1:0] slot_stamps [SLOTS];
    logic [COUNT_W-1:0] held      = '0;
    logic [STAMP_W-1:0] use_tick  = CLOCK_RESET;
    logic [COUNT_W-1:0] cap_limit = CAP_RESET;

    lru_result_t lru_outcomes [$];   // results still owed by the block, oldest first

    bit steady = 1'b0;               // no idling on either side while set
    int mismatches = 0;
    int n_requests = 0;
    int n_results  = 0;
    int n_victims  = 0;
    int n_refused  = 0;

    // Apply one request to the shadow table; queue its results when record is set.
    function automatic void step_lru_table(logic kind, logic [ID_W-1:0] id,
                                           logic [COUNT_W-1:0] want, bit record);
        int i;
        int c;
        int hit;
        int best;
        int take;
        int eff_cap;
        bit picked [SLOTS];
        lru_result_t r;
        hit     = -1;
        eff_cap = (cap_limit > SLOTS) ? SLOTS : int'(cap_limit);
        r.victim_id = '0;
        r.last      = 1'b1;
        if (kind == KIND_TOUCH) begin
            for (i = 0; i < held; i++)
                if (hit < 0 && slot_ids[i] == id)
                    hit = i;
            if (hit >= 0) begin
                slot_stamps[hit] = use_tick;
                use_tick++;
                r.status = ST_RESTAMP;
            end
            else if (held >= eff_cap) begin
                r.status = ST_FULL;
            end
            else begin
                slot_ids[held]    = id;
                slot_stamps[held] = use_tick;
                use_tick++;
                held++;
                r.status = ST_INSERT;
            end
            r.tracked_count = held;
            if (record)
                lru_outcomes.push_back(r);
        end
        else if (want == 0 || held == 0) begin
            r.status        = ST_NONE;
            r.tracked_count = held;
            if (record)
                lru_outcomes.push_back(r);
        end
        else begin
            take   = (want > held) ? int'(held) : int'(want);
            picked = '{default: 1'b0};
            // oldest stamp first, lower slot wins a tie
            for (c = 0; c < take; c++) begin
                best = -1;
                for (i = 0; i < held; i++)
                    if (!picked[i] && (best < 0 || slot_stamps[i] < slot_stamps[best]))
                        best = i;
                picked[best]    = 1'b1;
                r.status        = ST_VICTIM;
                r.victim_id     = slot_ids[best];
                r.tracked_count = held;
                r.last          = (c == take - 1);
                if (record)
                    lru_outcomes.push_back(r);
            end
        end
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_pause();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 50)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Touch id: an id already held (restamp) or a fresh random one.
    function automatic logic [ID_W-1:0] pick_touch_id(int fresh_pct);
        if (held != 0 && $urandom_range(0, 99) >= fresh_pct)
            return slot_ids[$urandom_range(0, held - 1)];
        return ID_W'($urandom_range(0, 16'hFFFF));
    endfunction

    // Present one request, wait for it to be taken, then maybe idle.
    task automatic send_request(logic kind, logic [ID_W-1:0] id, logic [COUNT_W-1:0] want,
                                bit typed, lru_result_t typed_result);
        int gap;
        req_bus.valid        <= 1'b1;
        req_bus.kind         <= kind;
        req_bus.line_id      <= id;
        req_bus.victim_count <= want;
        do
            @(posedge clk);
        while (!req_bus.ready);
        n_requests++;
        if (typed)
            lru_outcomes.push_back(typed_result);
        step_lru_table(kind, id, want, !typed);
        gap = pick_pause();
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Capacity writes only go in with the block drained and settled.
    task automatic write_capacity(logic [COUNT_W-1:0] value);
        req_bus.valid <= 1'b0;
        while (lru_outcomes.size() != 0)
            @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cap_limit = value;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: random back-pressure and in-order comparison.
    initial
    begin
        int hold;
        lru_result_t got;
        lru_result_t want_r;
        hold = 0;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
                got = '{rsp_bus.status, rsp_bus.victim_id, rsp_bus.tracked_count, rsp_bus.last};
                n_results++;
                if (lru_outcomes.size() == 0) begin
                    $display("%0t: unexpected result: status %0d id %h count %0d last %0d",
                             $time, got.status, got.victim_id, got.tracked_count, got.last);
                    mismatches++;
                end
                else begin
                    want_r = lru_outcomes.pop_front();
                    if (want_r.status == ST_VICTIM)
                        n_victims++;
                    if (want_r.status == ST_FULL)
                        n_refused++;
                    if (got !== want_r) begin
                        $display("%0t: mismatch: expected status %0d id %h count %0d last %0d,",
                                 $time, want_r.status, want_r.victim_id,
                                 want_r.tracked_count, want_r.last);
                        $display("    got status %0d id %h count %0d last %0d",
                                 got.status, got.victim_id, got.tracked_count, got.last);
                        mismatches++;
                    end
                end
            end
            if (!rst_n) begin
                rsp_bus.ready <= 1'b0;
            end
            else begin
                if (hold == 0 && $urandom_range(0, 99) < 30)
                    hold = pick_pause();
                rsp_bus.ready <= (hold == 0);
                if (hold > 0)
                    hold--;
            end
        end
    end

    // Watchdog: ends a run in which nothing moves for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: timeout, nothing accepted for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus: reset, directed table, then random phases at several capacities.
    initial
    begin
        int phase;
        int n;
        lru_result_t known;
        rst_n = 1'b0;
        req_bus.valid        <= 1'b0;
        req_bus.kind         <= KIND_TOUCH;
        req_bus.line_id      <= '0;
        req_bus.victim_count <= '0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[r])
        begin
            if (PLAN[r].op == ROW_CFG) begin
                write_capacity(PLAN[r].amount);
            end
            else begin
                known = '{PLAN[r].status, '0, PLAN[r].tracked, 1'b1};
                send_request(PLAN[r].kind, PLAN[r].line_id, PLAN[r].amount,
                             PLAN[r].typed, known);
            end
        end

        // Most requests are touches that either restamp a held id or bring a
        // new one; selects mostly ask a few victims, rarely a deep scan.
        for (phase = 0; phase < 5; phase++)
        begin
            write_capacity(PHASE_CAP[phase]);
            for (n = 0; n < PHASE_ITEMS[phase]; n++)
            begin
                if (n % 12 == 0)
                    steady = (phase == 1) || ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 99) < 70) begin
                    send_request(KIND_TOUCH, pick_touch_id(PHASE_FRESH[phase]),
                                 COUNT_W'($urandom_range(0, 64)), 1'b0, '0);
                end
                else begin
                    case ($urandom_range(0, 19))
                        0, 1:    known.tracked_count = '0;
                        19:      known.tracked_count = COUNT_W'($urandom_range(21, 64));
                        17, 18:  known.tracked_count = COUNT_W'($urandom_range(5, 20));
                        default: known.tracked_count = COUNT_W'($urandom_range(1, 4));
                    endcase
                    send_request(KIND_SELECT, ID_W'($urandom_range(0, 16'hFFFF)),
                                 known.tracked_count, 1'b0, '0);
                end
            end
        end
        steady = 1'b0;

        req_bus.valid <= 1'b0;
        while (lru_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests over a range of capacity settings; %0d results checked,",
                 n_requests, n_results);
        $display("%0d victims, %0d refused touches, final table size %0d",
                 n_victims, n_refused, held);
        if (mismatches == 0 && lru_outcomes.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
